### hw/rtl/phase_to_phase_impedance_assert.svh
// ----------------------------------------------------------------------------
// Phase-to-phase impedance assertion macros
// Clocked checks on clk with reset rst_n taken from the asserting scope.
// ----------------------------------------------------------------------------
`ifndef PHASE_TO_PHASE_IMPEDANCE_ASSERT_SVH
`define PHASE_TO_PHASE_IMPEDANCE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define PPZ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define PPZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ppz_pkg.sv
// ----------------------------------------------------------------------------
// Phase-to-phase impedance package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ppz_pkg;

    localparam int MAG_WIDTH_DEF     = 24;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CFG_W             = 24;
    localparam int ZW                = 34;
    localparam int QW                = 32;
    localparam logic [31:0] INVK     = 32'h9B74EDA8;
    localparam logic [9:0]  ZSCALE   = 10'd1000;

    // atan(2^-i), 2^31 = pi
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/ppz_if.sv
// ----------------------------------------------------------------------------
// Phase-to-phase impedance channels
// Phasor input, impedance result and threshold write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface ppz_src_if #(
    parameter int MAG_WIDTH   = 24,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic        [MAG_WIDTH-1:0]   current_a_mag;
    logic signed [ANGLE_WIDTH-1:0] current_a_ang;
    logic        [MAG_WIDTH-1:0]   current_b_mag;
    logic signed [ANGLE_WIDTH-1:0] current_b_ang;
    logic        [MAG_WIDTH-1:0]   current_c_mag;
    logic signed [ANGLE_WIDTH-1:0] current_c_ang;
    logic        [MAG_WIDTH-1:0]   voltage_a_mag;
    logic signed [ANGLE_WIDTH-1:0] voltage_a_ang;
    logic        [MAG_WIDTH-1:0]   voltage_b_mag;
    logic signed [ANGLE_WIDTH-1:0] voltage_b_ang;
    logic        [MAG_WIDTH-1:0]   voltage_c_mag;
    logic signed [ANGLE_WIDTH-1:0] voltage_c_ang;

    modport source (
        output valid, current_a_mag, current_a_ang, current_b_mag, current_b_ang,
               current_c_mag, current_c_ang, voltage_a_mag, voltage_a_ang,
               voltage_b_mag, voltage_b_ang, voltage_c_mag, voltage_c_ang,
        input  ready
    );
    modport sink (
        input  valid, current_a_mag, current_a_ang, current_b_mag, current_b_ang,
               current_c_mag, current_c_ang, voltage_a_mag, voltage_a_ang,
               voltage_b_mag, voltage_b_ang, voltage_c_mag, voltage_c_ang,
        output ready
    );
endinterface

interface ppz_res_if #(
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic        [31:0]            z_ab_mag;
    logic signed [ANGLE_WIDTH-1:0] z_ab_ang;
    logic        [31:0]            z_bc_mag;
    logic signed [ANGLE_WIDTH-1:0] z_bc_ang;
    logic        [31:0]            z_ca_mag;
    logic signed [ANGLE_WIDTH-1:0] z_ca_ang;

    modport source (
        output valid, z_ab_mag, z_ab_ang, z_bc_mag, z_bc_ang, z_ca_mag, z_ca_ang,
        input  ready
    );
    modport sink (
        input  valid, z_ab_mag, z_ab_ang, z_bc_mag, z_bc_ang, z_ca_mag, z_ca_ang,
        output ready
    );
endinterface

interface ppz_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] min_current_diff;

    modport source (output valid, min_current_diff, input ready);
    modport sink (input valid, min_current_diff, output ready);
endinterface

### hw/rtl/ppz_rot_cell.sv
// ----------------------------------------------------------------------------
// Rotation CORDIC cell
// One micro-rotation driving the residual phase towards zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppz_rot_cell #(
    parameter int W   = 48,
    parameter int ZW  = 34,
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out
);
    import ppz_pkg::*;

    logic signed [ZW-1:0] atan_c;
    logic signed [W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    assign atan_c = ZW'(atan_lut(5'(IDX)));

    always_comb
    begin
        if (!z_in[ZW-1])
        begin
            x_next = x_in - (y_in >>> IDX);
            y_next = y_in + (x_in >>> IDX);
            z_next = z_in - atan_c;
        end
        else
        begin
            x_next = x_in + (y_in >>> IDX);
            y_next = y_in - (x_in >>> IDX);
            z_next = z_in + atan_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

### hw/rtl/ppz_vec_cell.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One micro-rotation driving y towards zero and accumulating the phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppz_vec_cell #(
    parameter int W   = 48,
    parameter int ZW  = 34,
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out
);
    import ppz_pkg::*;

    logic signed [ZW-1:0] atan_c;
    logic signed [W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    assign atan_c = ZW'(atan_lut(5'(IDX)));

    always_comb
    begin
        if (!y_in[W-1])
        begin
            x_next = x_in + (y_in >>> IDX);
            y_next = y_in - (x_in >>> IDX);
            z_next = z_in + atan_c;
        end
        else
        begin
            x_next = x_in - (y_in >>> IDX);
            y_next = y_in + (x_in >>> IDX);
            z_next = z_in - atan_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

### hw/rtl/ppz_div_cell.sv
// ----------------------------------------------------------------------------
// Restoring divider cell
// Resolves one quotient bit and carries divisor and side tag along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ppz_div_cell #(
    parameter int RW = 80,
    parameter int VW = 47,
    parameter int TW = 18,
    parameter int SH = 31
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [31:0]   q_in,
    input  logic [VW-1:0] div_in,
    input  logic [TW-1:0] tag_in,
    output logic [RW-1:0] rem_out,
    output logic [31:0]   q_out,
    output logic [VW-1:0] div_out,
    output logic [TW-1:0] tag_out
);
    logic [RW-1:0] dv;
    logic [RW-1:0] rem_reg, rem_next;
    logic [31:0]   q_reg, q_next;
    logic [VW-1:0] div_reg;
    logic [TW-1:0] tag_reg;

    assign dv = RW'(div_in) << SH;

    always_comb
    begin
        rem_next = rem_in;
        q_next   = q_in;
        if (rem_in >= dv)
        begin
            rem_next   = rem_in - dv;
            q_next[SH] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            div_reg <= div_in;
            tag_reg <= tag_in;
        end
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign div_out = div_reg;
    assign tag_out = tag_reg;
endmodule

### hw/rtl/phase_to_phase_impedance.sv
// Throughput: one phasor set per cycle; the whole pipeline holds while the
// result word is not taken.
// Reset clears the stage valid bits and sets min_current_diff to 1.
// ----------------------------------------------------------------------------
// Phase-to-phase loop impedance
// Polar-to-rectangular CORDIC rows, loop differences, vectoring CORDIC rows
// and a restoring divider row, one cell per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "phase_to_phase_impedance_assert.svh"
module phase_to_phase_impedance #(
    parameter int MAG_WIDTH     = ppz_pkg::MAG_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ppz_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = ppz_pkg::CORDIC_STAGES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ppz_src_if.sink   src,
    ppz_res_if.source res,
    ppz_cfg_if.sink   cfg
);
    import ppz_pkg::*;

    localparam int W   = MAG_WIDTH + 24;
    localparam int VW  = W - 1;
    localparam int HW  = VW - 32;
    localparam int NW  = VW + 10;
    localparam int RW  = VW + 33;
    localparam int PW  = MAG_WIDTH + 32;
    localparam int AW  = ANGLE_WIDTH;
    localparam int TW  = AW + 2;
    localparam int S   = CORDIC_STAGES;
    localparam int L   = 2 * S + 38;
    localparam logic signed [ZW-1:0] PI_Z      = ZW'(64'sh80000000);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(64'sh40000000);
    localparam logic [31:0]          RND_A     = 32'(64'd1 << (31 - AW));

    logic                en;
    logic [L-1:0]        vld_reg, vld_next;
    logic [CFG_W-1:0]    min_reg;

    logic [MAG_WIDTH-1:0] mag_in [6];
    logic [AW-1:0]        ang_in [6];

    logic signed [W-1:0]  cx [6][0:S];
    logic signed [W-1:0]  cy [6][0:S];
    logic signed [ZW-1:0] cz [6][0:S];
    logic signed [W-1:0]  vx [6][0:S];
    logic signed [W-1:0]  vy [6][0:S];
    logic signed [ZW-1:0] vz [6][0:S];

    logic signed [W-1:0]  r0x_reg [6];
    logic signed [ZW-1:0] r0z_reg [6];
    logic signed [W-1:0]  r0x_next [6];
    logic signed [ZW-1:0] r0z_next [6];

    logic signed [W-1:0]  dx_reg [6];
    logic signed [W-1:0]  dy_reg [6];
    logic [2:0]           duz_reg;
    logic signed [W-1:0]  v0x_reg [6];
    logic signed [W-1:0]  v0y_reg [6];
    logic signed [ZW-1:0] v0z_reg [6];
    logic [2:0]           uz_pipe_reg [0:S];

    logic [VW-1:0]  vi_reg [3];
    logic [VW-1:0]  phi_reg [3];
    logic [63:0]    plo_reg [3];
    logic [NW-1:0]  num_reg [3];
    logic [AW-1:0]  ang_reg [3];
    logic [2:0]     uz1_reg;

    logic [RW-1:0]  rem_c [3][0:32];
    logic [31:0]    q_c   [3][0:32];
    logic [VW-1:0]  div_c [3][0:32];
    logic [TW-1:0]  tag_c [3][0:32];

    logic [RW-1:0]  rem0_reg [3];
    logic [VW-1:0]  div0_reg [3];
    logic [TW-1:0]  tag0_reg [3];

    logic [31:0]    zmag_reg [3];
    logic [AW-1:0]  zang_reg [3];

    assign en        = !vld_reg[L-1] || res.ready;
    assign src.ready = en;
    assign cfg.ready = 1'b1;

    assign mag_in[0] = src.current_a_mag;
    assign mag_in[1] = src.current_b_mag;
    assign mag_in[2] = src.current_c_mag;
    assign mag_in[3] = src.voltage_a_mag;
    assign mag_in[4] = src.voltage_b_mag;
    assign mag_in[5] = src.voltage_c_mag;
    assign ang_in[0] = src.current_a_ang;
    assign ang_in[1] = src.current_b_ang;
    assign ang_in[2] = src.current_c_ang;
    assign ang_in[3] = src.voltage_a_ang;
    assign ang_in[4] = src.voltage_b_ang;
    assign ang_in[5] = src.voltage_c_ang;

    // Control state
    assign vld_next = {vld_reg[L-2:0], src.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            min_reg <= CFG_W'(1);
        end
        else
        begin
            if (en)
                vld_reg <= vld_next;
            if (cfg.valid)
                min_reg <= cfg.min_current_diff;
        end
    end

    // Pre-scale by 1/K and fold the phase into the right half plane
    always_comb
    begin
        for (int p = 0; p < 6; p++)
        begin
            logic [PW-1:0]   prod;
            logic [PW-1:0]   rnd;
            logic [31:0]     ph;
            logic signed [W-1:0]  x0;
            logic signed [ZW-1:0] z0;
            prod = PW'(mag_in[p]) * PW'(INVK);
            rnd  = prod + PW'(32768);
            ph   = 32'({ang_in[p], {(32 - AW){1'b0}}});
            x0   = W'(rnd[PW-1:16]);
            z0   = ZW'($signed(ph));
            if (z0 > HALF_PI_Z)
            begin
                z0 = z0 - PI_Z;
                x0 = -x0;
            end
            else if (z0 < -HALF_PI_Z)
            begin
                z0 = z0 + PI_Z;
                x0 = -x0;
            end
            r0x_next[p] = x0;
            r0z_next[p] = z0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < 6; p++)
            begin
                r0x_reg[p] <= r0x_next[p];
                r0z_reg[p] <= r0z_next[p];
            end
        end
    end

    genvar gp, gi;
    generate
        for (gp = 0; gp < 6; gp++)
        begin : g_rot
            assign cx[gp][0] = r0x_reg[gp];
            assign cy[gp][0] = '0;
            assign cz[gp][0] = r0z_reg[gp];
            for (gi = 0; gi < S; gi++)
            begin : g_cell
                ppz_rot_cell #(.W(W), .ZW(ZW), .IDX(gi)) u_cell (
                    .clk   (clk),
                    .en    (en),
                    .x_in  (cx[gp][gi]),
                    .y_in  (cy[gp][gi]),
                    .z_in  (cz[gp][gi]),
                    .x_out (cx[gp][gi+1]),
                    .y_out (cy[gp][gi+1]),
                    .z_out (cz[gp][gi+1])
                );
            end
        end
    endgenerate

    // Loop differences: vectors 0..2 are currents, 3..5 voltages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                dx_reg[l]   <= cx[l][S] - cx[(l + 1) % 3][S];
                dy_reg[l]   <= cy[l][S] - cy[(l + 1) % 3][S];
                dx_reg[l+3] <= cx[l+3][S] - cx[(l + 1) % 3 + 3][S];
                dy_reg[l+3] <= cy[l+3][S] - cy[(l + 1) % 3 + 3][S];
                duz_reg[l]  <= (cx[l+3][S] == cx[(l + 1) % 3 + 3][S]) &&
                               (cy[l+3][S] == cy[(l + 1) % 3 + 3][S]);
            end
        end
    end

    // Flip left half plane vectors before vectoring
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (dx_reg[k][W-1])
                begin
                    v0x_reg[k] <= -dx_reg[k];
                    v0y_reg[k] <= -dy_reg[k];
                    v0z_reg[k] <= PI_Z;
                end
                else
                begin
                    v0x_reg[k] <= dx_reg[k];
                    v0y_reg[k] <= dy_reg[k];
                    v0z_reg[k] <= '0;
                end
            end
            uz_pipe_reg[0] <= duz_reg;
            for (int i = 1; i <= S; i++)
                uz_pipe_reg[i] <= uz_pipe_reg[i-1];
        end
    end

    generate
        for (gp = 0; gp < 6; gp++)
        begin : g_vec
            assign vx[gp][0] = v0x_reg[gp];
            assign vy[gp][0] = v0y_reg[gp];
            assign vz[gp][0] = v0z_reg[gp];
            for (gi = 0; gi < S; gi++)
            begin : g_cell
                ppz_vec_cell #(.W(W), .ZW(ZW), .IDX(gi)) u_cell (
                    .clk   (clk),
                    .en    (en),
                    .x_in  (vx[gp][gi]),
                    .y_in  (vy[gp][gi]),
                    .z_in  (vz[gp][gi]),
                    .x_out (vx[gp][gi+1]),
                    .y_out (vy[gp][gi+1]),
                    .z_out (vz[gp][gi+1])
                );
            end
        end
    endgenerate

    // Magnitudes, 1/K products, scaled numerator and angle difference
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [VW-1:0] mi;
                logic [VW-1:0] mu;
                logic [31:0]   d;
                mi = (vx[l][S] > 0) ? vx[l][S][VW-1:0] : '0;
                mu = (vx[l+3][S] > 0) ? vx[l+3][S][VW-1:0] : '0;
                d  = vz[l+3][S][31:0] - vz[l][S][31:0] + RND_A;
                vi_reg[l]  <= mi;
                phi_reg[l] <= VW'(HW'(mi >> 32)) * VW'(INVK);
                plo_reg[l] <= 64'(mi[31:0]) * 64'(INVK);
                num_reg[l] <= NW'(mu) * NW'(ZSCALE);
                ang_reg[l] <= d[31 -: AW];
            end
            uz1_reg <= uz_pipe_reg[S];
        end
    end

    // Threshold test, overflow test and divider load
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [RW-1:0] mk;
                logic          low_cur;
                logic          sat;
                mk      = RW'(phi_reg[l]) + RW'(plo_reg[l][63:32]);
                low_cur = (vi_reg[l] == '0) || (mk < RW'({min_reg, 16'b0}));
                sat     = RW'(num_reg[l]) >= (RW'(vi_reg[l]) << 16);
                rem0_reg[l] <= RW'(num_reg[l]) << 16;
                div0_reg[l] <= vi_reg[l];
                tag0_reg[l] <= {low_cur || uz1_reg[l], sat, ang_reg[l]};
            end
        end
    end

    generate
        for (gp = 0; gp < 3; gp++)
        begin : g_div
            assign rem_c[gp][0] = rem0_reg[gp];
            assign q_c[gp][0]   = '0;
            assign div_c[gp][0] = div0_reg[gp];
            assign tag_c[gp][0] = tag0_reg[gp];
            for (gi = 0; gi < QW; gi++)
            begin : g_cell
                ppz_div_cell #(.RW(RW), .VW(VW), .TW(TW), .SH(QW - 1 - gi)) u_cell (
                    .clk     (clk),
                    .en      (en),
                    .rem_in  (rem_c[gp][gi]),
                    .q_in    (q_c[gp][gi]),
                    .div_in  (div_c[gp][gi]),
                    .tag_in  (tag_c[gp][gi]),
                    .rem_out (rem_c[gp][gi+1]),
                    .q_out   (q_c[gp][gi+1]),
                    .div_out (div_c[gp][gi+1]),
                    .tag_out (tag_c[gp][gi+1])
                );
            end
        end
    endgenerate

    // Result word: zero, saturate or quotient
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (tag_c[l][QW][TW-1])
                begin
                    zmag_reg[l] <= '0;
                    zang_reg[l] <= '0;
                end
                else
                begin
                    zmag_reg[l] <= tag_c[l][QW][TW-2] ? '1 : q_c[l][QW];
                    zang_reg[l] <= tag_c[l][QW][AW-1:0];
                end
            end
        end
    end

    assign res.valid    = vld_reg[L-1];
    assign res.z_ab_mag = zmag_reg[0];
    assign res.z_ab_ang = zang_reg[0];
    assign res.z_bc_mag = zmag_reg[1];
    assign res.z_bc_ang = zang_reg[1];
    assign res.z_ca_mag = zmag_reg[2];
    assign res.z_ca_ang = zang_reg[2];

    `PPZ_ASSERT_NEXT(a_frozen_stall, !en, $stable(vld_reg), "pipeline moved during stall")
    `PPZ_ASSERT_NEXT(a_last_stage, en && vld_reg[L-2], res.valid, "result word lost")
    `PPZ_ASSERT_NEXT(a_accept_enters, src.valid && src.ready, vld_reg[0], "accepted word dropped")
endmodule
